// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Each macro checks a property on the rising edge of aclk, outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sct_pkg.sv =====
// Package for the shell command tokenizer: scan modes, token codes, byte codes,
// and the token and bundle types passed from the lexer front to the emitter.
`timescale 1ns / 1ps

package sct_pkg;

    localparam logic [31:0] MAX_SOURCE_LEN = 32'd65535;
    localparam logic [15:0] LINE_LIMIT =
        (MAX_SOURCE_LEN < 32'd65535) ? MAX_SOURCE_LEN[15:0] : 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_AMP     = 3'd1,
        MODE_QUOTE   = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_ARG     = 3'd4
    } mode_t;

    localparam logic [2:0] TK_PIPE   = 3'd0;
    localparam logic [2:0] TK_AND_IF = 3'd1;
    localparam logic [2:0] TK_AMP    = 3'd2;
    localparam logic [2:0] TK_STRING = 3'd3;
    localparam logic [2:0] TK_EOD    = 3'd4;
    localparam logic [2:0] TK_ERROR  = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_AMP     = 8'd38;
    localparam logic [7:0] CH_QUOTE   = 8'd39;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_SEMI    = 8'd59;
    localparam logic [7:0] CH_PIPE    = 8'd124;
    localparam logic [7:0] CH_HASH    = 8'd35;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
    } token_t;

    // Up to two tokens caused by one input item; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } bundle_t;

    localparam int TDATA_W = 40;

endpackage

// ===== rtl/sct_front.sv =====
// Lexer front end: accepts input items, tracks the scan mode and offsets,
// and forms a bundle of up to two tokens per item. Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic             in_end,
    input  logic [7:0]       in_byte,
    output logic             push,
    output sct_pkg::bundle_t push_bundle
);

    typedef struct packed {
        sct_pkg::mode_t mode;
        logic [15:0]    tbegin;
        logic           pipe;
    } start_t;

    sct_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    pos_reg, pos_next;
    logic [15:0]    beg_reg, beg_next;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == sct_pkg::CH_SPACE) || ((b >= sct_pkg::CH_TAB) && (b <= sct_pkg::CH_CR));
    endfunction

    function automatic logic ends_arg(input logic [7:0] b);
        return (b == sct_pkg::CH_SPACE) || (b == sct_pkg::CH_AMP) ||
               (b == sct_pkg::CH_PIPE) || (b == sct_pkg::CH_SEMI) ||
               (b == sct_pkg::CH_LPAREN) || (b == sct_pkg::CH_RPAREN);
    endfunction

    // Lexes a byte at a token start, from idle mode or where an ampersand or argument ends.
    function automatic start_t start_tok(input logic [7:0] b, input logic [15:0] p,
                                         input logic [15:0] cur_beg);
        start_t s;
        s.mode   = sct_pkg::MODE_IDLE;
        s.tbegin = cur_beg;
        s.pipe   = 1'b0;
        if (is_ws(b)) begin
            s.mode = sct_pkg::MODE_IDLE;
        end else if (b == sct_pkg::CH_PIPE) begin
            s.pipe = 1'b1;
        end else if (b == sct_pkg::CH_AMP) begin
            s.mode   = sct_pkg::MODE_AMP;
            s.tbegin = p;
        end else if (b == sct_pkg::CH_QUOTE) begin
            s.mode   = sct_pkg::MODE_QUOTE;
            s.tbegin = p + 16'd1;
        end else if (b == sct_pkg::CH_HASH) begin
            s.mode = sct_pkg::MODE_COMMENT;
        end else begin
            s.mode   = sct_pkg::MODE_ARG;
            s.tbegin = p;
        end
        return s;
    endfunction

    function automatic sct_pkg::bundle_t put_tok(input sct_pkg::bundle_t bin,
                                                 input logic [2:0] k,
                                                 input logic [15:0] off,
                                                 input logic [15:0] len);
        sct_pkg::bundle_t bo;
        sct_pkg::token_t  t;
        bo       = bin;
        t.kind   = k;
        t.offset = off;
        t.length = len;
        if (bin.count == 2'd0) begin
            bo.first = t;
            bo.count = 2'd1;
        end else begin
            bo.second = t;
            bo.count  = 2'd2;
        end
        return bo;
    endfunction

    always_comb begin
        sct_pkg::bundle_t bnd;
        start_t           st;
        bnd       = '0;
        st        = '0;
        mode_next = mode_reg;
        pos_next  = pos_reg;
        beg_next  = beg_reg;
        if (in_accept) begin
            if (in_end) begin
                case (mode_reg)
                    sct_pkg::MODE_AMP:   bnd = put_tok(bnd, sct_pkg::TK_AMP, beg_reg, 16'd1);
                    sct_pkg::MODE_QUOTE: bnd = put_tok(bnd, sct_pkg::TK_ERROR, 16'd0, 16'd0);
                    sct_pkg::MODE_ARG:
                        bnd = put_tok(bnd, sct_pkg::TK_STRING, beg_reg, pos_reg - beg_reg);
                    default: ;
                endcase
                bnd       = put_tok(bnd, sct_pkg::TK_EOD, pos_reg, 16'd0);
                mode_next = sct_pkg::MODE_IDLE;
                pos_next  = 16'd0;
                beg_next  = 16'd0;
            end else if (pos_reg < sct_pkg::LINE_LIMIT) begin
                pos_next = pos_reg + 16'd1;
                st       = start_tok(in_byte, pos_reg, beg_reg);
                case (mode_reg)
                    sct_pkg::MODE_AMP: begin
                        mode_next = sct_pkg::MODE_IDLE;
                        if (in_byte == sct_pkg::CH_AMP) begin
                            bnd = put_tok(bnd, sct_pkg::TK_AND_IF, beg_reg, 16'd2);
                        end else begin
                            bnd       = put_tok(bnd, sct_pkg::TK_AMP, beg_reg, 16'd1);
                            mode_next = st.mode;
                            beg_next  = st.tbegin;
                            if (st.pipe) begin
                                bnd = put_tok(bnd, sct_pkg::TK_PIPE, pos_reg, 16'd1);
                            end
                        end
                    end
                    sct_pkg::MODE_QUOTE: begin
                        if (in_byte == sct_pkg::CH_QUOTE) begin
                            bnd = put_tok(bnd, sct_pkg::TK_STRING, beg_reg, pos_reg - beg_reg);
                            mode_next = sct_pkg::MODE_IDLE;
                        end
                    end
                    sct_pkg::MODE_COMMENT: begin
                        if (in_byte == sct_pkg::CH_NEWLINE) begin
                            mode_next = sct_pkg::MODE_IDLE;
                        end
                    end
                    sct_pkg::MODE_ARG: begin
                        if (ends_arg(in_byte)) begin
                            bnd = put_tok(bnd, sct_pkg::TK_STRING, beg_reg, pos_reg - beg_reg);
                            mode_next = st.mode;
                            beg_next  = st.tbegin;
                            if (st.pipe) begin
                                bnd = put_tok(bnd, sct_pkg::TK_PIPE, pos_reg, 16'd1);
                            end
                        end
                    end
                    default: begin
                        mode_next = st.mode;
                        beg_next  = st.tbegin;
                        if (st.pipe) begin
                            bnd = put_tok(bnd, sct_pkg::TK_PIPE, pos_reg, 16'd1);
                        end
                    end
                endcase
            end
        end
        push_bundle = bnd;
        push        = bnd.count != 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sct_pkg::MODE_IDLE;
            pos_reg  <= 16'd0;
            beg_reg  <= 16'd0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            beg_reg  <= beg_next;
        end
    end

endmodule

// ===== rtl/sct_queue.sv =====
// Small FIFO of token bundles between the lexer front and the token emitter.
// Depends on sct_pkg for the bundle type.
`timescale 1ns / 1ps

module sct_queue #(
    parameter int DEPTH = sct_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sct_pkg::bundle_t push_bundle,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output sct_pkg::bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sct_pkg::bundle_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_FULL;
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ===== rtl/sct_back.sv =====
// Token emitter: takes bundles from the queue and sends their tokens one per
// cycle while m_tready is high, through a registered output stage. Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        empty,
    input  sct_pkg::bundle_t            head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sct_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    logic            valid_reg, valid_next;
    logic            second_reg, second_next;
    sct_pkg::token_t tok_reg, tok_next;
    logic            last_reg, last_next;
    logic            load;
    logic            is_last;

    always_comb begin
        load        = !empty && (!valid_reg || m_tready);
        is_last     = second_reg || (head.count != 2'd2);
        pop         = load && is_last;
        valid_next  = valid_reg;
        second_next = second_reg;
        tok_next    = tok_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next  = 1'b1;
            tok_next    = second_reg ? head.second : head.first;
            last_next   = is_last;
            second_next = !is_last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, tok_reg.length, tok_reg.offset, tok_reg.kind};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/shell_command_tokenizer_top.sv =====
// Shell command tokenizer: one byte item per cycle in, one token per cycle out
// while m_tready is high. An item is lexed in the cycle it is accepted and its
// tokens (zero, one or two) go into a queue of QUEUE_DEPTH bundles; the emitter
// drains one token per cycle, so input rate stays one item per cycle while the
// queue has room; an item that yields two tokens stays at the queue head until
// both are loaded into the output register, which every token passes through.
// Depends on sct_pkg and the front, queue and back modules.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module shell_command_tokenizer_top #(
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] char_byte
    input  logic [0:0]                  s_tuser,  // [0] kind: 0 byte, 1 end of source
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sct_pkg::TDATA_W-1:0] m_tdata,  // [2:0] token_kind, [18:3] token_offset,
                                                  // [34:19] token_length, [39:35] zero
    output logic                        m_tlast   // last_of_run
);

    logic             in_accept;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    sct_pkg::bundle_t push_bundle;
    sct_pkg::bundle_t q_head;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    sct_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_end      (s_tuser[0]),
        .in_byte     (s_tdata),
        .push        (q_push),
        .push_bundle (push_bundle)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_bundle (push_bundle),
        .pop         (q_pop),
        .full        (q_full),
        .empty       (q_empty),
        .head        (q_head)
    );

    sct_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front only writes when the queue has room.
    `ASSERT_CLK(a_no_push_full, !q_push || !q_full, "bundle pushed into a full queue")
    // With nothing queued and nothing shown, no token may appear.
    `ASSERT_NEXT(a_no_phantom, q_empty && !m_tvalid, !m_tvalid, "token appeared from nowhere")
    // An end item always yields at least the end_of_data token.
    `ASSERT_NEXT(a_end_yields, in_accept && s_tuser[0], !q_empty || m_tvalid,
                 "end item produced no token")

endmodule

// ===== verif/shell_command_tokenizer_top_tb.sv =====
// Self-checking testbench for shell_command_tokenizer_top: drives command lines
// byte by byte, predicts the token stream and compares every token it receives.
// Depends on sct_pkg and the tokenizer RTL only.
`timescale 1ns / 1ps

module shell_command_tokenizer_top_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 370;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        sct_pkg::token_t tok;
        logic            last;
    } exp_token_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;
    logic [0:0]                  s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [sct_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;

    // Predicted lexer state.
    sct_pkg::mode_t lex_mode;
    logic [15:0]    lex_pos;
    logic [15:0]    tok_begin;

    exp_token_t pending_tokens[$];
    exp_token_t step_tokens[$];

    int  items_sent;
    int  tokens_seen;
    int  lines_sent;
    int  mismatches;
    int  unexpected;
    int  idle_cycles;
    int  rx_stall;
    bit  quiet;

    shell_command_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return (b == sct_pkg::CH_SPACE) || (b >= sct_pkg::CH_TAB && b <= sct_pkg::CH_CR);
    endfunction

    function automatic bit ends_word(logic [7:0] b);
        return b == sct_pkg::CH_SPACE || b == sct_pkg::CH_AMP || b == sct_pkg::CH_PIPE ||
               b == sct_pkg::CH_SEMI || b == sct_pkg::CH_LPAREN || b == sct_pkg::CH_RPAREN;
    endfunction

    function automatic void add_token(logic [2:0] kind, logic [15:0] off, logic [15:0] len);
        exp_token_t t;
        if (step_tokens.size() >= 2)
            return;
        t.tok.kind   = kind;
        t.tok.offset = off;
        t.tok.length = len;
        t.last       = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void begin_token(logic [7:0] b, logic [15:0] p);
        if (is_blank(b))
            return;
        if (b == sct_pkg::CH_PIPE) begin
            add_token(sct_pkg::TK_PIPE, p, 16'd1);
        end else if (b == sct_pkg::CH_AMP) begin
            lex_mode  = sct_pkg::MODE_AMP;
            tok_begin = p;
        end else if (b == sct_pkg::CH_QUOTE) begin
            lex_mode  = sct_pkg::MODE_QUOTE;
            tok_begin = p + 16'd1;
        end else if (b == sct_pkg::CH_HASH) begin
            lex_mode = sct_pkg::MODE_COMMENT;
        end else begin
            lex_mode  = sct_pkg::MODE_ARG;
            tok_begin = p;
        end
    endfunction

    function automatic void lex_reset();
        lex_mode  = sct_pkg::MODE_IDLE;
        lex_pos   = 16'd0;
        tok_begin = 16'd0;
    endfunction

    // Works out the tokens one accepted item causes and queues them.
    function automatic void lex_item(logic kind, logic [7:0] b);
        logic [15:0] p;
        exp_token_t  t;
        p = lex_pos;
        step_tokens.delete();
        if (kind) begin
            case (lex_mode)
                sct_pkg::MODE_AMP:   add_token(sct_pkg::TK_AMP, tok_begin, 16'd1);
                sct_pkg::MODE_QUOTE: add_token(sct_pkg::TK_ERROR, 16'd0, 16'd0);
                sct_pkg::MODE_ARG:   add_token(sct_pkg::TK_STRING, tok_begin, p - tok_begin);
                default: ;
            endcase
            add_token(sct_pkg::TK_EOD, p, 16'd0);
            lex_reset();
        end else if (p < sct_pkg::LINE_LIMIT) begin
            lex_pos = p + 16'd1;
            case (lex_mode)
                sct_pkg::MODE_AMP: begin
                    lex_mode = sct_pkg::MODE_IDLE;
                    if (b == sct_pkg::CH_AMP) begin
                        add_token(sct_pkg::TK_AND_IF, tok_begin, 16'd2);
                    end else begin
                        add_token(sct_pkg::TK_AMP, tok_begin, 16'd1);
                        begin_token(b, p);
                    end
                end
                sct_pkg::MODE_QUOTE: begin
                    if (b == sct_pkg::CH_QUOTE) begin
                        add_token(sct_pkg::TK_STRING, tok_begin, p - tok_begin);
                        lex_mode = sct_pkg::MODE_IDLE;
                    end
                end
                sct_pkg::MODE_COMMENT: begin
                    if (b == sct_pkg::CH_NEWLINE)
                        lex_mode = sct_pkg::MODE_IDLE;
                end
                sct_pkg::MODE_ARG: begin
                    if (ends_word(b)) begin
                        add_token(sct_pkg::TK_STRING, tok_begin, p - tok_begin);
                        lex_mode = sct_pkg::MODE_IDLE;
                        begin_token(b, p);
                    end
                end
                default: begin
                    lex_mode = sct_pkg::MODE_IDLE;
                    begin_token(b, p);
                end
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) begin
            t = step_tokens[i];
            pending_tokens.push_back(t);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic kind, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        lex_item(kind, b);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic end_line();
        send_item(1'b1, 8'($urandom_range(0, 255)));
        lines_sent++;
    endtask

    // Holds the input idle until every predicted token has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_tokens.size() != 0)
            @(negedge aclk);
    endtask

    task automatic test_operators();
        // The last '|' closes a lone '&' and is a pipe itself: two tokens.
        send_text("|&&&|");
        end_line();
        // A lone '&' flushed by the end item.
        send_text("&");
        end_line();
    endtask

    task automatic test_quotes();
        send_text("''");
        end_line();
        // Unterminated quote ends in an error token.
        send_text("'\tq");
        end_line();
    endtask

    task automatic test_comments_blanks();
        send_text(" \v\f#a\n;");
        end_line();
        end_line();
    endtask

    task automatic test_arguments();
        send_item(1'b0, 8'h00);
        send_item(1'b0, sct_pkg::CH_NEWLINE);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, sct_pkg::CH_LPAREN);
        send_text(")x y&");
        end_line();
    endtask

    task automatic test_random_lines();
        logic [7:0] line[$];
        logic [7:0] c;
        int target;
        int len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            line.delete();
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 15) begin
                len = $urandom_range(1, 8);
                repeat (len) line.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 8))
                        0: repeat ($urandom_range(1, 2)) begin
                            if ($urandom_range(0, 1))
                                line.push_back(sct_pkg::CH_SPACE);
                            else
                                line.push_back(sct_pkg::CH_TAB + 8'($urandom_range(0, 4)));
                        end
                        1: line.push_back(sct_pkg::CH_PIPE);
                        2: begin
                            line.push_back(sct_pkg::CH_AMP);
                            line.push_back(sct_pkg::CH_AMP);
                        end
                        3: line.push_back(sct_pkg::CH_AMP);
                        4: begin
                            line.push_back(sct_pkg::CH_QUOTE);
                            repeat ($urandom_range(0, 4)) begin
                                do c = 8'($urandom_range(0, 255));
                                while (c == sct_pkg::CH_QUOTE);
                                line.push_back(c);
                            end
                            if ($urandom_range(0, 7) != 0)
                                line.push_back(sct_pkg::CH_QUOTE);
                        end
                        5: begin
                            line.push_back(sct_pkg::CH_HASH);
                            repeat ($urandom_range(0, 3)) begin
                                do c = 8'($urandom_range(0, 255));
                                while (c == sct_pkg::CH_NEWLINE);
                                line.push_back(c);
                            end
                            if ($urandom_range(0, 5) != 0)
                                line.push_back(sct_pkg::CH_NEWLINE);
                        end
                        6, 7: repeat ($urandom_range(1, 5)) begin
                            if ($urandom_range(0, 1)) begin
                                line.push_back(8'($urandom_range(8'h61, 8'h7A)));
                            end else begin
                                do c = 8'($urandom_range(0, 255)); while (ends_word(c));
                                line.push_back(c);
                            end
                        end
                        default: begin
                            case ($urandom_range(0, 2))
                                0: line.push_back(sct_pkg::CH_SEMI);
                                1: line.push_back(sct_pkg::CH_LPAREN);
                                default: line.push_back(sct_pkg::CH_RPAREN);
                            endcase
                        end
                    endcase
                    if ($urandom_range(0, 1))
                        line.push_back(sct_pkg::CH_SPACE);
                end
            end
            foreach (line[i])
                send_item(1'b0, line[i]);
            end_line();
            if (lines_sent % 8 == 0)
                wait_drained();
        end
        quiet = 1'b0;
    endtask

    // Output side: random stalls of random length.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (rx_stall > 0) begin
            m_tready = 1'b0;
            rx_stall--;
        end else begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin
        exp_token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
                unexpected++;
                $display("unexpected token: kind %0d offset %0d length %0d last %0b",
                         m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast);
            end else begin
                want = pending_tokens.pop_front();
                if (m_tdata[2:0] !== want.tok.kind || m_tdata[18:3] !== want.tok.offset ||
                    m_tdata[34:19] !== want.tok.length || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"token mismatch: expected kind %0d offset %0d length %0d ",
                                  "last %0b, got kind %0d offset %0d length %0d last %0b"},
                                 want.tok.kind, want.tok.offset, want.tok.length, want.last,
                                 m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast);
                end
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d tokens outstanding",
                         IDLE_LIMIT, pending_tokens.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        items_sent  = 0;
        tokens_seen = 0;
        lines_sent  = 0;
        mismatches  = 0;
        unexpected  = 0;
        idle_cycles = 0;
        rx_stall    = 0;
        quiet       = 1'b0;
        lex_reset();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_operators();
        test_quotes();
        test_comments_blanks();
        test_arguments();
        test_random_lines();

        s_tvalid = 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d items in %0d lines and checked %0d tokens.",
                 items_sent, lines_sent, tokens_seen);
        $display("Covered operators, quotes, comments, delimiters and random lines.");
        if (mismatches == 0 && unexpected == 0 && pending_tokens.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing tokens",
                     mismatches, unexpected, pending_tokens.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_queue.sv
rtl/sct_back.sv
rtl/shell_command_tokenizer_top.sv
verif/shell_command_tokenizer_top_tb.sv
